FILE: rtl/dmwbc_pkg.sv
// dmwbc_pkg: sizes, address split, register codes and the controller/datapath
// command and status bundles of the direct-mapped write-back cache.
// No dependencies; imported by every module of the block.
`default_nettype none

package dmwbc_pkg;

    localparam int CACHE_BYTES  = 4096;
    localparam int BLOCK_BYTES  = 64;
    localparam int WORD_BYTES   = 4;
    localparam int MEMORY_BYTES = 65536;

    localparam int ADDR_W      = 16;
    localparam int WORD_W      = 32;
    localparam int CFG_W       = 10;
    localparam int COST_W      = 32;
    localparam int CFG_IDX_W   = 2;

    localparam int BLOCK_WORDS = BLOCK_BYTES / WORD_BYTES;
    localparam int LINE_COUNT  = CACHE_BYTES / BLOCK_BYTES;
    localparam int CACHE_WORDS = CACHE_BYTES / WORD_BYTES;
    localparam int MEM_WORDS   = MEMORY_BYTES / WORD_BYTES;

    localparam int BYTE_W   = $clog2(WORD_BYTES);
    localparam int OFF_W    = $clog2(BLOCK_WORDS);
    localparam int LINE_W   = $clog2(LINE_COUNT);
    localparam int TAG_W    = $clog2(MEMORY_BYTES) - $clog2(CACHE_BYTES);
    localparam int CIDX_W   = LINE_W + OFF_W;
    localparam int MEM_AW   = $clog2(MEM_WORDS);
    localparam int CNT_W    = $clog2(BLOCK_WORDS + 1);

    // stream payload layout
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_USER_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MEM_RD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEM_WR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CACHE_RD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CACHE_WR = 2'd3;

    localparam logic [CFG_W-1:0] MEM_RD_RST   = 10'd100;
    localparam logic [CFG_W-1:0] MEM_WR_RST   = 10'd50;
    localparam logic [CFG_W-1:0] CACHE_RD_RST = 10'd1;
    localparam logic [CFG_W-1:0] CACHE_WR_RST = 10'd1;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic accept;
        logic lookup;
        logic cnt_clear;
        logic wb_step;
        logic fill_step;
        logic clr_step;
        logic install;
        logic access;
        logic add_mw;
        logic add_mr;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic victim_dirty;
        logic cnt_done;
        logic clr_done;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

FILE: rtl/dmwbc_datapath.sv
// dmwbc_datapath: tag and data stores, backing memory, block copy counter,
// cost registers, running cost total and the output register.
// Depends on dmwbc_pkg; driven by dmwbc_ctrl.
`default_nettype none

module dmwbc_datapath
    import dmwbc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic                  s_tuser,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    input  wire logic                  m_tready,
    input  wire cmd_t                  cmd,
    output status_t                    st,
    output logic                       m_tvalid,
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic [OUT_USER_W-1:0]      m_tuser
);

    logic [WORD_W-1:0] cache_mem [CACHE_WORDS];
    logic [WORD_W-1:0] back_mem  [MEM_WORDS];
    logic [TAG_W-1:0]  tag_mem   [LINE_COUNT];

    logic [LINE_COUNT-1:0] valid_reg;
    logic [LINE_COUNT-1:0] dirty_reg;

    logic              wr_cmd_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [LINE_W-1:0] line_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [WORD_W-1:0] wdata_reg;
    logic [TAG_W-1:0]  tag_q_reg;
    logic              hit_reg;
    logic              wb_flag_reg;

    logic [CNT_W-1:0]  cnt_reg;
    logic [OFF_W-1:0]  idx_d_reg;
    logic              pend_reg;
    logic [MEM_AW-1:0] clr_reg;

    logic [WORD_W-1:0] cache_rdata_reg;
    logic [WORD_W-1:0] mem_rdata_reg;

    logic [CFG_W-1:0]  mem_rd_cost_reg;
    logic [CFG_W-1:0]  mem_wr_cost_reg;
    logic [CFG_W-1:0]  cache_rd_cost_reg;
    logic [CFG_W-1:0]  cache_wr_cost_reg;
    logic [COST_W-1:0] cost_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_USER_W-1:0] out_user_reg;

    logic [ADDR_W-1:0]  in_addr;
    logic [LINE_W-1:0]  in_line;
    logic               cnt_done;
    logic               mem_we;
    logic [MEM_AW-1:0]  mem_waddr;
    logic [WORD_W-1:0]  mem_wdata;
    logic               mem_re;
    logic [MEM_AW-1:0]  mem_raddr;
    logic               cache_we;
    logic [CIDX_W-1:0]  cache_waddr;
    logic [WORD_W-1:0]  cache_wdata;
    logic               cache_re;
    logic [CIDX_W-1:0]  cache_raddr;
    logic [CFG_W-1:0]   cost_pick;
    logic               cost_add;

    assign in_addr  = s_tdata[ADDR_W-1:0];
    assign in_line  = in_addr[BYTE_W+OFF_W +: LINE_W];
    assign cnt_done = (cnt_reg == CNT_W'(BLOCK_WORDS));

    assign st.hit          = valid_reg[line_reg] && (tag_q_reg == tag_reg);
    assign st.victim_dirty = valid_reg[line_reg] && dirty_reg[line_reg];
    assign st.cnt_done     = cnt_done;
    assign st.clr_done     = (clr_reg == MEM_AW'(MEM_WORDS - 1));
    assign st.out_free     = !out_valid_reg || m_tready;

    // backing memory port: clear sweep, write-back, fill reads
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_reg;
        mem_wdata = '0;
        if (cmd.clr_step)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.wb_step && pend_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = {tag_q_reg, line_reg, idx_d_reg};
            mem_wdata = cache_rdata_reg;
        end
        mem_re    = cmd.fill_step && !cnt_done;
        mem_raddr = {tag_reg, line_reg, cnt_reg[OFF_W-1:0]};
    end

    // cache data port: victim reads, fill writes, the word access itself
    always_comb
    begin
        cache_we    = 1'b0;
        cache_waddr = {line_reg, idx_d_reg};
        cache_wdata = mem_rdata_reg;
        cache_re    = 1'b0;
        cache_raddr = {line_reg, cnt_reg[OFF_W-1:0]};
        if (cmd.fill_step && pend_reg)
        begin
            cache_we = 1'b1;
        end
        else if (cmd.access && wr_cmd_reg == CMD_WRITE)
        begin
            cache_we    = 1'b1;
            cache_waddr = {line_reg, off_reg};
            cache_wdata = wdata_reg;
        end
        if (cmd.wb_step && !cnt_done)
        begin
            cache_re = 1'b1;
        end
        else if (cmd.access && wr_cmd_reg == CMD_READ)
        begin
            cache_re    = 1'b1;
            cache_raddr = {line_reg, off_reg};
        end
    end

    always_comb
    begin
        cost_add  = 1'b1;
        cost_pick = '0;
        if (cmd.add_mw)
        begin
            cost_pick = mem_wr_cost_reg;
        end
        else if (cmd.add_mr)
        begin
            cost_pick = mem_rd_cost_reg;
        end
        else if (cmd.access)
        begin
            cost_pick = (wr_cmd_reg == CMD_WRITE) ? cache_wr_cost_reg : cache_rd_cost_reg;
        end
        else
        begin
            cost_add = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            back_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= back_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cache_we)
        begin
            cache_mem[cache_waddr] <= cache_wdata;
        end
        if (cache_re)
        begin
            cache_rdata_reg <= cache_mem[cache_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.install)
        begin
            tag_mem[line_reg] <= tag_reg;
        end
        if (cmd.accept)
        begin
            tag_q_reg <= tag_mem[in_line];
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            wr_cmd_reg <= s_tuser;
            tag_reg    <= in_addr[ADDR_W-1 -: TAG_W];
            line_reg   <= in_line;
            off_reg    <= in_addr[BYTE_W +: OFF_W];
            wdata_reg  <= s_tdata[ADDR_W +: WORD_W];
        end
        if (cmd.lookup)
        begin
            hit_reg <= st.hit;
        end
        idx_d_reg <= cnt_reg[OFF_W-1:0];
        if (cmd.load_out)
        begin
            out_data_reg <= {cost_reg,
                             (wr_cmd_reg == CMD_WRITE) ? {WORD_W{1'b0}} : cache_rdata_reg};
            out_user_reg <= {wb_flag_reg, hit_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg         <= '0;
            dirty_reg         <= '0;
            wb_flag_reg       <= 1'b0;
            cnt_reg           <= '0;
            pend_reg          <= 1'b0;
            clr_reg           <= '0;
            cost_reg          <= '0;
            out_valid_reg     <= 1'b0;
            mem_rd_cost_reg   <= MEM_RD_RST;
            mem_wr_cost_reg   <= MEM_WR_RST;
            cache_rd_cost_reg <= CACHE_RD_RST;
            cache_wr_cost_reg <= CACHE_WR_RST;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MEM_RD:   mem_rd_cost_reg   <= cfg_data;
                    REG_MEM_WR:   mem_wr_cost_reg   <= cfg_data;
                    REG_CACHE_RD: cache_rd_cost_reg <= cfg_data;
                    REG_CACHE_WR: cache_wr_cost_reg <= cfg_data;
                    default:      ;
                endcase
            end
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + MEM_AW'(1);
            end
            if (cmd.accept)
            begin
                wb_flag_reg <= 1'b0;
            end
            else if (cmd.add_mw)
            begin
                wb_flag_reg <= 1'b1;
            end
            if (cmd.cnt_clear)
            begin
                cnt_reg <= '0;
            end
            else if ((cmd.wb_step || cmd.fill_step) && !cnt_done)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            // read issued this cycle lands in the next one
            pend_reg <= (cmd.wb_step || cmd.fill_step) && !cnt_done;
            if (cmd.install)
            begin
                valid_reg[line_reg] <= 1'b1;
                dirty_reg[line_reg] <= 1'b0;
            end
            else if (cmd.access && wr_cmd_reg == CMD_WRITE)
            begin
                dirty_reg[line_reg] <= 1'b1;
            end
            if (cost_add)
            begin
                cost_reg <= cost_reg + {{(COST_W-CFG_W){1'b0}}, cost_pick};
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

`default_nettype wire

FILE: rtl/dmwbc_ctrl.sv
// dmwbc_ctrl: controller state machine of the cache: memory clear sweep,
// lookup, write-back, fill, word access and result hand-off.
// Depends on dmwbc_pkg; drives dmwbc_datapath through cmd_t.
`default_nettype none

module dmwbc_ctrl
    import dmwbc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire status_t st,
    output cmd_t         cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_LOOKUP = 3'd2;
    localparam logic [2:0] S_WB     = 3'd3;
    localparam logic [2:0] S_FILL   = 3'd4;
    localparam logic [2:0] S_ACCESS = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                cmd.lookup    = 1'b1;
                cmd.cnt_clear = 1'b1;
                if (st.hit)
                begin
                    state_next = S_ACCESS;
                end
                else if (st.victim_dirty)
                begin
                    state_next = S_WB;
                end
                else
                begin
                    state_next = S_FILL;
                end
            end
            S_WB:
            begin
                cmd.wb_step = 1'b1;
                if (st.cnt_done)
                begin
                    cmd.add_mw    = 1'b1;
                    cmd.cnt_clear = 1'b1;
                    state_next    = S_FILL;
                end
            end
            S_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (st.cnt_done)
                begin
                    cmd.add_mr  = 1'b1;
                    cmd.install = 1'b1;
                    state_next  = S_ACCESS;
                end
            end
            S_ACCESS:
            begin
                cmd.access = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/direct_mapped_writeback_cache.sv
// From input word accepted to result valid, a read or write hit passes through
// lookup, word access and result hand-off; a clean miss adds a block fill, and a
// dirty miss adds a block write-back before the fill. One word in flight at a time,
// so a new word is taken only once the last result is loaded; the output register lets the
// next word enter while a result waits. After reset the backing memory is swept
// to zero, all 16384 words, with s_tready low; config writes are taken meanwhile.
`default_nettype none

module direct_mapped_writeback_cache
    import dmwbc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // byte_address, write_word
    input  wire logic                  s_tuser,   // command
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // read_word, elapsed_cost
    output logic [OUT_USER_W-1:0]      m_tuser,   // was_hit, wrote_back
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data
);

    cmd_t    cmd;
    status_t st;

    dmwbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    dmwbc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .st        (st),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

FILE: rtl/dmwbc_checker.sv
// dmwbc_port_assert: port-level assertions for the cache top level, bound in below.
// Depends on dmwbc_pkg.
`default_nettype none

module dmwbc_port_assert
    import dmwbc_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata,
    input wire logic [OUT_USER_W-1:0] m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // one word in flight: no second accept right behind the first
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while previous word still in work");

    // a write-back only happens on a miss
    a_wb_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> !m_tuser[0])
        else $error("write-back reported on a hit");

endmodule

bind direct_mapped_writeback_cache dmwbc_port_assert u_dmwbc_port_assert (.*);

`default_nettype wire
